@@ hw/rtl/mdpval_pkg.sv @@
// Types and constants shared by the markdown path validator.
`default_nettype none

package mdpval_pkg;

  localparam int unsigned COUNT_W = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX          = 13'h1FFF;
  localparam logic [COUNT_W-1:0] MD_MIN_LEN         = 13'd3;
  localparam logic [COUNT_W-1:0] MAX_PATH_LEN_RESET = 13'd4096;

  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_LOWER_M = 8'h6D;
  localparam logic [7:0] CHAR_UPPER_M = 8'h4D;
  localparam logic [7:0] CHAR_LOWER_D = 8'h64;
  localparam logic [7:0] CHAR_UPPER_D = 8'h44;
  localparam logic [7:0] CTRL_LIMIT   = 8'h20;
  localparam logic [7:0] CHAR_DEL     = 8'h7F;

  localparam logic [1:0] SEG_DOTDOT = 2'd2;
  localparam logic [1:0] SEG_MAX    = 2'd3;

  localparam logic [1:0] STAT_MISSING = 2'd0;
  localparam logic [1:0] STAT_REGULAR = 2'd1;

  typedef enum logic [2:0] {
    ERR_OK            = 3'd0,
    ERR_PAGE          = 3'd1,
    ERR_NOT_MARKDOWN  = 3'd2,
    ERR_TOO_LONG      = 3'd3,
    ERR_BAD_CHARACTER = 3'd4,
    ERR_TRAVERSAL     = 3'd5,
    ERR_NOT_FOUND     = 3'd6,
    ERR_NOT_REGULAR   = 3'd7
  } entry_error_t;

  typedef struct packed {
    logic         valid;
    entry_error_t code;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/mdpval_if.sv @@
// Handshake interfaces for path byte beats and result beats.
`default_nettype none

interface mdpval_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       byte_present;
  logic       is_last;
  logic       source_is_page;
  logic [1:0] stat_kind;

  modport source (
    output valid, path_byte, byte_present, is_last, source_is_page, stat_kind,
    input  ready
  );
  modport sink (
    input  valid, path_byte, byte_present, is_last, source_is_page, stat_kind,
    output ready
  );
endinterface

interface mdpval_out_if;
  logic                      valid;
  logic                      ready;
  mdpval_pkg::entry_error_t  entry_error;

  modport source (output valid, entry_error, input ready);
  modport sink (input valid, entry_error, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mdpval_path_tracker.sv @@
// Per-path state update and final error judgment.
`default_nettype none

module mdpval_path_tracker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire logic [7:0]                        path_byte,
  input  wire logic                              byte_present,
  input  wire logic                              is_last,
  input  wire logic                              source_is_page,
  input  wire logic [1:0]                        stat_kind,
  input  wire logic [mdpval_pkg::COUNT_W-1:0]    limit,
  output mdpval_pkg::result_t                    result
);
  import mdpval_pkg::*;

  logic [COUNT_W-1:0] length_count, length_count_next;
  logic [3:0][7:0]    tail_bytes, tail_bytes_next;
  logic               control_seen, control_seen_next;
  logic               traversal_seen, traversal_seen_next;
  logic [1:0]         segment_count, segment_count_next;
  logic               segment_all_dots, segment_all_dots_next;

  logic [COUNT_W-1:0] cnt;
  logic [3:0][7:0]    tail;
  logic               ctrl;
  logic               trav;
  logic [1:0]         seg;
  logic               dots;
  logic               md_suffix;
  logic               dotdot;
  entry_error_t       code;

  always_comb begin
    cnt  = length_count;
    tail = tail_bytes;
    ctrl = control_seen;
    trav = traversal_seen;
    seg  = segment_count;
    dots = segment_all_dots;
    if (accept && byte_present) begin
      if (cnt != COUNT_MAX) begin
        cnt = cnt + 1'b1;
      end
      tail = {tail_bytes[2:0], path_byte};
      if (path_byte < CTRL_LIMIT || path_byte == CHAR_DEL) begin
        ctrl = 1'b1;
      end
      if (path_byte == CHAR_SLASH) begin
        if (segment_count == SEG_DOTDOT && segment_all_dots) begin
          trav = 1'b1;
        end
        seg  = 2'd0;
        dots = 1'b1;
      end else begin
        if (path_byte != CHAR_DOT) begin
          dots = 1'b0;
        end
        if (seg != SEG_MAX) begin
          seg = seg + 1'b1;
        end
      end
    end

    md_suffix = (cnt > MD_MIN_LEN) && (tail[2] == CHAR_DOT) &&
                (tail[1] == CHAR_LOWER_M || tail[1] == CHAR_UPPER_M) &&
                (tail[0] == CHAR_LOWER_D || tail[0] == CHAR_UPPER_D) &&
                (tail[3] != CHAR_SLASH) && (tail[3] != CHAR_DOT);
    dotdot = (seg == SEG_DOTDOT) && dots;

    priority if (source_is_page) begin
      code = ERR_PAGE;
    end else if (!md_suffix) begin
      code = ERR_NOT_MARKDOWN;
    end else if (cnt == COUNT_MAX || cnt > limit) begin
      code = ERR_TOO_LONG;
    end else if (ctrl) begin
      code = ERR_BAD_CHARACTER;
    end else if (trav || dotdot) begin
      code = ERR_TRAVERSAL;
    end else if (stat_kind == STAT_MISSING) begin
      code = ERR_NOT_FOUND;
    end else if (stat_kind != STAT_REGULAR) begin
      code = ERR_NOT_REGULAR;
    end else begin
      code = ERR_OK;
    end

    result.valid = accept && is_last;
    result.code  = code;

    if (accept && is_last) begin
      length_count_next     = '0;
      tail_bytes_next       = '0;
      control_seen_next     = 1'b0;
      traversal_seen_next   = 1'b0;
      segment_count_next    = 2'd0;
      segment_all_dots_next = 1'b1;
    end else begin
      length_count_next     = cnt;
      tail_bytes_next       = tail;
      control_seen_next     = ctrl;
      traversal_seen_next   = trav;
      segment_count_next    = seg;
      segment_all_dots_next = dots;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_count     <= '0;
      tail_bytes       <= '0;
      control_seen     <= 1'b0;
      traversal_seen   <= 1'b0;
      segment_count    <= 2'd0;
      segment_all_dots <= 1'b1;
    end else begin
      length_count     <= length_count_next;
      tail_bytes       <= tail_bytes_next;
      control_seen     <= control_seen_next;
      traversal_seen   <= traversal_seen_next;
      segment_count    <= segment_count_next;
      segment_all_dots <= segment_all_dots_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mdpval_result_buffer.sv @@
// Output register with a skid entry for result beats.
`default_nettype none

module mdpval_result_buffer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mdpval_pkg::result_t  push,
  output logic                      push_ready,
  mdpval_out_if.source              result_out
);
  import mdpval_pkg::*;

  logic         out_valid;
  entry_error_t out_code;
  logic         skid_valid;
  entry_error_t skid_code;

  assign push_ready             = !skid_valid;
  assign result_out.valid       = out_valid;
  assign result_out.entry_error = out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !result_out.ready) begin
      if (push.valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !result_out.ready) begin
      if (push.valid) begin
        skid_code <= push.code;
      end
    end else if (skid_valid) begin
      out_code <= skid_code;
    end else if (push.valid) begin
      out_code <= push.code;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/markdown_path_validator_top.sv @@
// Top level of the markdown path validator.
//
//   Channel         Dir   Beat contents
//   path_in         in    path_byte, byte_present, is_last, source_is_page, stat_kind
//   result_out      out   entry_error, one beat per path
//   cfg_write_*     in    max_path_len, written when cfg_write_en is high
//
// One path byte is taken per cycle while path_in is ready; the result of a path,
// judged by the single update-and-judge stage, is registered for result_out.
// Reset is synchronous and clears all path state; the limit returns to 4096, capped at MAX_PATH_BOUND.
// A stalled result waits in the output register while one more result fits
// in the skid entry; only when both are full does path_in drop ready.
`default_nettype none

module markdown_path_validator_top #(
  parameter int unsigned MAX_PATH_BOUND = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write_en,
  input  wire logic [mdpval_pkg::COUNT_W-1:0]  cfg_write_data,
  mdpval_in_if.sink                            path_in,
  mdpval_out_if.source                         result_out
);
  import mdpval_pkg::*;

  localparam logic [16:0] BOUND = 17'(MAX_PATH_BOUND);
  localparam logic [COUNT_W-1:0] RESET_LIMIT =
    (17'(MAX_PATH_LEN_RESET) > BOUND) ? BOUND[COUNT_W-1:0] : MAX_PATH_LEN_RESET;

  logic [COUNT_W-1:0] limit;
  logic               accept;
  logic               push_ready;
  result_t            push;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= RESET_LIMIT;
    end else if (cfg_write_en) begin
      if (17'(cfg_write_data) > BOUND) begin
        limit <= BOUND[COUNT_W-1:0];
      end else begin
        limit <= cfg_write_data;
      end
    end
  end

  assign path_in.ready = push_ready;
  assign accept        = path_in.valid && push_ready;

  mdpval_path_tracker u_tracker (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .path_byte      (path_in.path_byte),
    .byte_present   (path_in.byte_present),
    .is_last        (path_in.is_last),
    .source_is_page (path_in.source_is_page),
    .stat_kind      (path_in.stat_kind),
    .limit          (limit),
    .result         (push)
  );

  mdpval_result_buffer u_buffer (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

@@ hw/rtl/mdpval_checker.sv @@
// Port-level assertions for the markdown path validator, bound to the top level.
`default_nettype none

module mdpval_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_is_last,
  input wire logic       in_source_is_page,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_entry_error
);
  import mdpval_pkg::*;

  // A stalled result beat stays and keeps its code.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_error))
    else $error("result beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Input stalls only when both result slots are taken.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty output");

  // A page-initiated path reaching an empty output is reported next cycle.
  a_page_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_is_last && in_source_is_page && !out_valid
    |=> out_valid && out_entry_error == ERR_PAGE)
    else $error("page-initiated path not reported");

endmodule

bind markdown_path_validator_top mdpval_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (path_in.valid),
  .in_ready          (path_in.ready),
  .in_is_last        (path_in.is_last),
  .in_source_is_page (path_in.source_is_page),
  .out_valid         (result_out.valid),
  .out_ready         (result_out.ready),
  .out_entry_error   (result_out.entry_error)
);

`default_nettype wire
